>>> sv/aebf_pkg.sv
// Package for the alpha edge bleed fill block: sizes, register map,
// pixel and control structures, and the offset square helper.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package aebf_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int MAX_REACH   = 8;
	localparam int RESET_REACH = 5;

	localparam int XW      = $clog2(MAX_WIDTH);
	localparam int YW      = $clog2(MAX_HEIGHT);
	localparam int WIDTH_W = XW + 1;
	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW      = $clog2(DEPTH);

	localparam int DIM_W = 9;
	localparam int RCH_W = 4;
	localparam int OFF_W = $clog2(MAX_REACH) + 1;
	localparam int SQ_W  = 2 * $clog2(MAX_REACH) + 1;
	localparam int D_W   = SQ_W + 1;

	localparam int PADDR_W = 4;
	localparam int IDX_W   = 2;
	localparam int DATA_W  = 32;

	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_REACH  = 2'd2;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic [XW-1:0]      x_max;
		logic [YW-1:0]      y_max;
		logic [WIDTH_W-1:0] width;
		logic [RCH_W-1:0]   reach;
	} cfg_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		pixel_t        wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} ram_req_t;

	function automatic logic [SQ_W-1:0] off_sq(input logic signed [OFF_W-1:0] v);
		logic [OFF_W-1:0] mag;
		logic [SQ_W-1:0]  m;
		mag = (v < 0) ? OFF_W'(-v) : OFF_W'(v);
		m   = SQ_W'(mag);
		return SQ_W'(m * m);
	endfunction

endpackage

`default_nettype wire

>>> sv/aebf_frame_ram.sv
// Frame store: one write port and one registered read port.
// Depends on aebf_pkg for depth, address width and the pixel word.
`timescale 1ns / 1ps
`default_nettype none

module aebf_frame_ram (
	input  wire logic              clk,
	input  wire aebf_pkg::ram_req_t req,
	output aebf_pkg::pixel_t       rdata
);
	import aebf_pkg::*;

	pixel_t mem [0:DEPTH-1];
	pixel_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> sv/aebf_regs.sv
// Configuration registers behind the APB-style port, with the clamped
// image geometry handed to the fill engine. Depends on aebf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aebf_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [aebf_pkg::PADDR_W-1:0] paddr,
	input  wire logic [aebf_pkg::DATA_W-1:0]  pwdata,
	output logic [aebf_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	output aebf_pkg::cfg_t                    cfg,
	output logic                              restart
);
	import aebf_pkg::*;

	logic [DIM_W-1:0]   image_width_q;
	logic [DIM_W-1:0]   image_height_q;
	logic [RCH_W-1:0]   feather_reach_q;
	logic [IDX_W-1:0]   idx;
	logic               wr_en;
	logic [WIDTH_W-1:0] eff_w;
	logic [YW:0]        eff_h;

	assign idx    = paddr[PADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= DIM_W'(256);
			image_height_q  <= DIM_W'(256);
			feather_reach_q <= RCH_W'(RESET_REACH);
		end else if (wr_en) begin
			unique case (idx)
				REG_WIDTH:  image_width_q   <= pwdata[DIM_W-1:0];
				REG_HEIGHT: image_height_q  <= pwdata[DIM_W-1:0];
				REG_REACH:  feather_reach_q <= pwdata[RCH_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:  restart = wr_en;
			REG_HEIGHT: restart = wr_en;
			REG_REACH:  restart = wr_en;
			default:    restart = 1'b0;
		endcase
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = DATA_W'(image_width_q);
			REG_HEIGHT: prdata = DATA_W'(image_height_q);
			REG_REACH:  prdata = DATA_W'(feather_reach_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		if (image_width_q == '0) begin
			eff_w = WIDTH_W'(1);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WIDTH_W'(MAX_WIDTH);
		end else begin
			eff_w = WIDTH_W'(image_width_q);
		end
		if (image_height_q == '0) begin
			eff_h = (YW+1)'(1);
		end else if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = (YW+1)'(MAX_HEIGHT);
		end else begin
			eff_h = (YW+1)'(image_height_q);
		end
		cfg.width = eff_w;
		cfg.x_max = XW'(eff_w - WIDTH_W'(1));
		cfg.y_max = YW'(eff_h - (YW+1)'(1));
		if (32'(feather_reach_q) > 32'(MAX_REACH)) begin
			cfg.reach = RCH_W'(MAX_REACH);
		end else begin
			cfg.reach = feather_reach_q;
		end
	end

endmodule

`default_nettype wire

>>> sv/aebf_fill_engine.sv
// Fill engine: load and emit positions, the window scan sequencer over the
// frame store read port, nearest-opaque selection and the output register.
// Depends on aebf_pkg; drives the frame store through a ram_req_t.
`timescale 1ns / 1ps
`default_nettype none

module aebf_fill_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire aebf_pkg::cfg_t    cfg,
	input  wire logic              restart,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              action,
	input  wire aebf_pkg::pixel_t  in_pix,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output aebf_pkg::pixel_t       out_pix,
	output logic                   out_last,
	output aebf_pkg::ram_req_t     ram_req,
	input  wire aebf_pkg::pixel_t  ram_rdata
);
	import aebf_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CENTER = 6'b000010,
		ST_SETUP  = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_HOLD   = 6'b100000
	} state_t;

	state_t state_q;

	logic [AW-1:0] lpos_q, epos_q;
	logic [XW-1:0] lx_q, ex_q;
	logic [YW-1:0] ly_q, ey_q;

	logic [XW-1:0] nx0_q, nx1_q, sx_q;
	logic [YW-1:0] ny1_q, sy_q;
	logic [AW-1:0] row_base_q;

	logic                    cand_s1;
	logic signed [OFF_W-1:0] dx_s1, dy_s1;

	logic          found_q;
	logic [D_W-1:0] best_q;
	logic [23:0]   pick_q;
	logic [7:0]    alpha_q;

	logic          out_valid_q;
	pixel_t        out_pix_q;
	logic          out_last_q;

	logic          in_fire, load_fire, req_fire, hold_fire;
	logic          load_end, emit_end;
	logic [XW:0]   rx, lo_x_diff, hi_x_sum;
	logic [YW:0]   ry, lo_y_diff, hi_y_sum;
	logic [XW-1:0] nx0, nx1;
	logic [YW-1:0] ny0, ny1;
	logic signed [OFF_W-1:0] dx, dy;
	logic [D_W-1:0] cand_dist;
	logic          take;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid & ~in_stall;
	assign load_fire = in_fire & ~action;
	assign req_fire  = in_fire & action;
	assign hold_fire = (state_q == ST_HOLD) & (~out_valid_q | ~out_stall);

	assign load_end = (lx_q == cfg.x_max) && (ly_q == cfg.y_max);
	assign emit_end = (ex_q == cfg.x_max) && (ey_q == cfg.y_max);

	always_comb begin
		rx        = (XW+1)'(cfg.reach);
		ry        = (YW+1)'(cfg.reach);
		lo_x_diff = {1'b0, ex_q} - rx;
		lo_y_diff = {1'b0, ey_q} - ry;
		hi_x_sum  = {1'b0, ex_q} + rx - (XW+1)'(1);
		hi_y_sum  = {1'b0, ey_q} + ry - (YW+1)'(1);
		nx0 = ({1'b0, ex_q} >= rx) ? lo_x_diff[XW-1:0] : '0;
		ny0 = ({1'b0, ey_q} >= ry) ? lo_y_diff[YW-1:0] : '0;
		nx1 = (hi_x_sum > {1'b0, cfg.x_max}) ? cfg.x_max : hi_x_sum[XW-1:0];
		ny1 = (hi_y_sum > {1'b0, cfg.y_max}) ? cfg.y_max : hi_y_sum[YW-1:0];
	end

	always_comb begin
		dx        = $signed(OFF_W'({1'b0, sx_q} - {1'b0, ex_q}));
		dy        = $signed(OFF_W'({1'b0, sy_q} - {1'b0, ey_q}));
		cand_dist = D_W'(off_sq(dx_s1)) + D_W'(off_sq(dy_s1));
		take = cand_s1 && (ram_rdata.alpha != 8'd0) && (!found_q || (cand_dist < best_q));
	end

	always_comb begin
		ram_req.we    = load_fire;
		ram_req.waddr = lpos_q;
		ram_req.wdata = in_pix;
		ram_req.re    = req_fire | (state_q == ST_SCAN);
		ram_req.raddr = (state_q == ST_SCAN) ? (row_base_q + AW'(sx_q)) : epos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lpos_q      <= '0;
			lx_q        <= '0;
			ly_q        <= '0;
			epos_q      <= '0;
			ex_q        <= '0;
			ey_q        <= '0;
			cand_s1     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cand_s1     <= (state_q == ST_SCAN);
			out_valid_q <= hold_fire | (out_valid_q & out_stall);
			if (take) begin
				found_q <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (load_fire) begin
						if (load_end) begin
							lpos_q <= '0;
							lx_q   <= '0;
							ly_q   <= '0;
						end else begin
							lpos_q <= lpos_q + AW'(1);
							if (lx_q == cfg.x_max) begin
								lx_q <= '0;
								ly_q <= ly_q + YW'(1);
							end else begin
								lx_q <= lx_q + XW'(1);
							end
						end
					end
					if (req_fire) begin
						state_q <= ST_CENTER;
					end
				end
				ST_CENTER: begin
					if (ram_rdata.alpha != 8'd0) begin
						found_q <= 1'b1;
						state_q <= ST_HOLD;
					end else begin
						found_q <= 1'b0;
						state_q <= (cfg.reach == '0) ? ST_HOLD : ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sx_q == nx1_q && sy_q == ny1_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (hold_fire) begin
						state_q <= ST_IDLE;
						if (emit_end) begin
							epos_q <= '0;
							ex_q   <= '0;
							ey_q   <= '0;
						end else begin
							epos_q <= epos_q + AW'(1);
							if (ex_q == cfg.x_max) begin
								ex_q <= '0;
								ey_q <= ey_q + YW'(1);
							end else begin
								ex_q <= ex_q + XW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (restart) begin
				lpos_q <= '0;
				lx_q   <= '0;
				ly_q   <= '0;
				epos_q <= '0;
				ex_q   <= '0;
				ey_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= dx;
		dy_s1 <= dy;
		if (take) begin
			best_q <= cand_dist;
			pick_q <= ram_rdata[23:0];
		end
		unique case (state_q)
			ST_CENTER: begin
				nx0_q   <= nx0;
				nx1_q   <= nx1;
				ny1_q   <= ny1;
				sx_q    <= nx0;
				sy_q    <= ny0;
				alpha_q <= ram_rdata.alpha;
				if (ram_rdata.alpha != 8'd0) begin
					pick_q <= ram_rdata[23:0];
				end
			end
			ST_SETUP: begin
				row_base_q <= AW'(sy_q) * AW'(cfg.width);
			end
			ST_SCAN: begin
				if (sx_q == nx1_q) begin
					sx_q       <= nx0_q;
					sy_q       <= sy_q + YW'(1);
					row_base_q <= row_base_q + AW'(cfg.width);
				end else begin
					sx_q <= sx_q + XW'(1);
				end
			end
			default: ;
		endcase
		if (hold_fire) begin
			out_pix_q  <= found_q ? {alpha_q, pick_q} : 32'd0;
			out_last_q <= emit_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix   = out_pix_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

>>> sv/alpha_edge_bleed_fill_core.sv
// Top level of the alpha edge bleed fill block: configuration registers,
// fill engine and frame store. Depends on aebf_pkg and the three submodules.
//
// Words with action 0 load RGBA pixels in raster order into the frame store;
// a word with action 1 returns the next pixel in raster order, with
// transparent pixels filled from the nearest opaque neighbor in their
// window. A load is written into the store as it is taken. A request for
// an opaque pixel, or with reach zero, ends after the centre read; else
// the engine scans the window, clipped at the image borders and at most
// (2F)^2 pixels, over the store's single read port, one neighbor per cycle.
// A finished word waits in the output register while the next word is taken.
// The store is not cleared after reset, so pixels must be loaded before
// they are requested. Any register write restarts both positions at zero.
`timescale 1ns / 1ps
`default_nettype none

module alpha_edge_bleed_fill_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [aebf_pkg::PADDR_W-1:0] paddr,
	input  wire logic [aebf_pkg::DATA_W-1:0]  pwdata,
	output logic [aebf_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         action,
	input  wire logic [7:0]                   in_red,
	input  wire logic [7:0]                   in_green,
	input  wire logic [7:0]                   in_blue,
	input  wire logic [7:0]                   in_alpha,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [7:0]                        out_red,
	output logic [7:0]                        out_green,
	output logic [7:0]                        out_blue,
	output logic [7:0]                        out_alpha,
	output logic                              last_pixel
);
	import aebf_pkg::*;

	cfg_t     cfg;
	logic     restart;
	pixel_t   in_pix;
	pixel_t   out_pix;
	ram_req_t ram_req;
	pixel_t   ram_rdata;

	assign in_pix.red   = in_red;
	assign in_pix.green = in_green;
	assign in_pix.blue  = in_blue;
	assign in_pix.alpha = in_alpha;

	assign out_red   = out_pix.red;
	assign out_green = out_pix.green;
	assign out_blue  = out_pix.blue;
	assign out_alpha = out_pix.alpha;

	aebf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.restart (restart)
	);

	aebf_fill_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.restart   (restart),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.in_pix    (in_pix),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_pix   (out_pix),
		.out_last  (last_pixel),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	aebf_frame_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire
